// ===== src/mer_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  // Field widths fixed by the transaction formats.
  localparam int REQ_W      = 2;
  localparam int CH_FIELD_W = 3;
  localparam int CAP_W      = 16;
  localparam int REG_W      = 16;
  localparam int RAW_W      = 14;
  localparam int CFG_IDX_W  = 1;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_CAPTURE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TRIGGER  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EVALUATE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT   = 1'd1;

  localparam logic [REG_W-1:0] TIMER_PERIOD_RST = 16'd50000;
  localparam logic [REG_W-1:0] JUMP_LIMIT_RST   = 16'd100;

  // Scaling width*17/100. A product width*17 at or above SAT_LIMIT gives a
  // distance beyond RAW_MAX, so only DIV_IN_W bits enter the divide. The
  // divide by 100 is a multiply by ceil(2^32/100), exact below 2^30.
  localparam int          SCALE_SHIFT = 4;
  localparam int          DIV_IN_W    = 21;
  localparam int          RECIP_W     = 26;
  localparam int          RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0]  RECIP    = 26'd42949673;
  localparam logic [DIV_IN_W-1:0] SAT_LIMIT = 21'd1638400;
  localparam logic [RAW_W-1:0]    RAW_MAX   = 14'd16383;

  // Control of the state memories.
  typedef struct packed {
    logic rd_en;
    logic edge_we;
    logic prev_we;
  } store_ctrl_t;

endpackage

`default_nettype wire

// ===== src/mer_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mer_req_if;
  logic                         valid;
  logic                         ready;
  logic [mer_pkg::REQ_W-1:0]      req_type;
  logic [mer_pkg::CH_FIELD_W-1:0] channel_index;
  logic [mer_pkg::CAP_W-1:0]      capture_value;

  modport source (output valid, req_type, channel_index, capture_value, input ready);
  modport sink   (input valid, req_type, channel_index, capture_value, output ready);
endinterface

`default_nettype wire

// ===== src/mer_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mer_res_if;
  logic                           valid;
  logic                           ready;
  logic [mer_pkg::CH_FIELD_W-1:0] out_channel;
  logic [mer_pkg::RAW_W-1:0]      raw_distance;
  logic [mer_pkg::RAW_W-1:0]      accepted_distance;
  logic                           jump_rejected;
  logic                           last_result;

  modport source (output valid, out_channel, raw_distance, accepted_distance,
                  jump_rejected, last_result, input ready);
  modport sink   (input valid, out_channel, raw_distance, accepted_distance,
                  jump_rejected, last_result, output ready);
endinterface

`default_nettype wire

// ===== src/mer_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mer_store #(
  parameter int CHANNELS    = 6,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire mer_pkg::store_ctrl_t                            ctrl_i,
  input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr_i,
  input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] edge_wr_addr_i,
  input  wire logic [COUNT_WIDTH-1:0]                          edge_wr_start_i,
  input  wire logic [COUNT_WIDTH-1:0]                          edge_wr_end_i,
  input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] prev_wr_addr_i,
  input  wire logic [mer_pkg::RAW_W-1:0]                       prev_wr_data_i,
  output logic      [COUNT_WIDTH-1:0]                          rd_start_o,
  output logic      [COUNT_WIDTH-1:0]                          rd_end_o,
  output logic      [mer_pkg::RAW_W-1:0]                       rd_prev_o
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [2*COUNT_WIDTH-1:0]    edge_mem [CHANNELS];
  logic [mer_pkg::RAW_W-1:0]   prev_mem [CHANNELS];

  logic [CHANNELS-1:0]         edge_vld_q;
  logic [CHANNELS-1:0]         prev_vld_q;

  logic [2*COUNT_WIDTH-1:0]    rd_edge_q;
  logic [mer_pkg::RAW_W-1:0]   rd_prev_q;
  logic                        rd_evld_q;
  logic                        rd_pvld_q;

  // An entry that was never written reads as zero, its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_vld_q <= '0;
      prev_vld_q <= '0;
      rd_evld_q  <= 1'b0;
      rd_pvld_q  <= 1'b0;
    end else begin
      if (ctrl_i.edge_we) begin
        edge_vld_q[edge_wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.prev_we) begin
        prev_vld_q[prev_wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_evld_q <= edge_vld_q[rd_addr_i];
        rd_pvld_q <= prev_vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.edge_we) begin
      edge_mem[edge_wr_addr_i] <= {edge_wr_start_i, edge_wr_end_i};
    end
    if (ctrl_i.prev_we) begin
      prev_mem[prev_wr_addr_i] <= prev_wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_edge_q <= edge_mem[rd_addr_i];
      rd_prev_q <= prev_mem[rd_addr_i];
    end
  end

  assign rd_start_o = rd_evld_q ? rd_edge_q[2*COUNT_WIDTH-1:COUNT_WIDTH] : '0;
  assign rd_end_o   = rd_evld_q ? rd_edge_q[COUNT_WIDTH-1:0] : '0;
  assign rd_prev_o  = rd_pvld_q ? rd_prev_q : '0;

endmodule

`default_nettype wire

// ===== src/mer_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mer_calc #(
  parameter int COUNT_WIDTH = 16,
  parameter int TAG_W       = 18
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      vld_i,
  input  wire logic [COUNT_WIDTH-1:0]    start_i,
  input  wire logic [COUNT_WIDTH-1:0]    end_i,
  input  wire logic [mer_pkg::REG_W-1:0] period_i,
  input  wire logic [TAG_W-1:0]          tag_i,
  output logic                           vld_o,
  output logic      [mer_pkg::RAW_W-1:0] raw_o,
  output logic      [TAG_W-1:0]          tag_o,
  output logic                           busy_o
);

  localparam int PW = (COUNT_WIDTH + 5 > mer_pkg::DIV_IN_W) ?
                      COUNT_WIDTH + 5 : mer_pkg::DIV_IN_W;
  localparam int MW = mer_pkg::DIV_IN_W + mer_pkg::RECIP_W;

  logic                      b_vld_q, c_vld_q, d_vld_q;
  logic [COUNT_WIDTH-1:0]    w_d, w_q;
  logic [PW-1:0]             p_d, p_q;
  logic [MW-1:0]             prod;
  logic [mer_pkg::RAW_W-1:0] raw_d, raw_q;
  logic [TAG_W-1:0]          b_tag_q, c_tag_q, d_tag_q;

  // When the end is not above the start the count wrapped once; the sum is
  // taken modulo the counter width.
  always_comb begin
    if (start_i < end_i) begin
      w_d = end_i - start_i;
    end else begin
      w_d = COUNT_WIDTH'(period_i) - start_i + end_i;
    end
  end

  assign p_d  = (PW'(w_q) << mer_pkg::SCALE_SHIFT) + PW'(w_q);
  assign prod = MW'(p_q[mer_pkg::DIV_IN_W-1:0]) * MW'(mer_pkg::RECIP);

  always_comb begin
    if (p_q >= PW'(mer_pkg::SAT_LIMIT)) begin
      raw_d = mer_pkg::RAW_MAX;
    end else begin
      raw_d = prod[mer_pkg::RECIP_SHIFT +: mer_pkg::RAW_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= vld_i;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q     <= w_d;
      b_tag_q <= tag_i;
      p_q     <= p_d;
      c_tag_q <= b_tag_q;
      raw_q   <= raw_d;
      d_tag_q <= c_tag_q;
    end
  end

  assign vld_o  = d_vld_q;
  assign raw_o  = raw_q;
  assign tag_o  = d_tag_q;
  assign busy_o = b_vld_q | c_vld_q | d_vld_q;

endmodule

`default_nettype wire

// ===== src/multi_channel_echo_ranger.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transaction
// req_i     in         capture edge, trigger re-arm, or evaluate all channels
// res_o     out        one distance result per channel of an evaluate
// cfg       in         write of timer_period or jump_limit
//
// A capture reads the channel entry, then writes it back; a trigger only re-arms.
// An evaluate issues one channel read per cycle unless the result stalls; the
// result pipeline is 5 deep; requests wait until the read stage and calc are empty.
// Reset clears per-entry valid bits; unwritten entries read as zero, no clearing pass.
// A stalled result freezes the whole evaluation pipeline, memory reads included.

module multi_channel_echo_ranger #(
  parameter int CHANNELS    = 6,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mer_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mer_pkg::REG_W-1:0]     cfg_data_i,
  mer_req_if.sink                            req_i,
  mer_res_if.source                          res_o
);

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAG_W = mer_pkg::RAW_W + AW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CAP  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]                state_q;
  logic [AW-1:0]             cnt_q;
  logic [CHANNELS-1:0]       exp_q;
  logic [mer_pkg::REG_W-1:0] period_q, limit_q;

  logic                      in_acc, adv, issue, cnt_last, cap_ok;
  logic [AW-1:0]             in_ch;

  logic [AW-1:0]             cap_ch_q;
  logic [COUNT_WIDTH-1:0]    cap_val_q;
  logic                      cap_rise_q;

  logic                      a_vld_q, a_last_q;
  logic [AW-1:0]             a_ch_q;

  mer_pkg::store_ctrl_t      st_ctrl;
  logic [AW-1:0]             rd_addr;
  logic [COUNT_WIDTH-1:0]    rd_start, rd_end, wr_start, wr_end;
  logic [mer_pkg::RAW_W-1:0] rd_prev;

  logic                      calc_vld, calc_busy;
  logic [mer_pkg::RAW_W-1:0] calc_raw, d_prev, diff;
  logic [TAG_W-1:0]          calc_tag;
  logic [AW-1:0]             d_ch;
  logic                      d_last, reject;

  logic                      out_vld_q;
  logic [mer_pkg::CH_FIELD_W-1:0] out_ch_q;
  logic [mer_pkg::RAW_W-1:0] out_raw_q, out_acc_q;
  logic                      out_rej_q, out_last_q;

  assign req_i.ready = (state_q == ST_IDLE) && !a_vld_q && !calc_busy;
  assign in_acc      = req_i.valid && req_i.ready;
  assign adv         = !out_vld_q || res_o.ready;
  assign issue       = (state_q == ST_EVAL) && adv;
  assign cnt_last    = cnt_q == AW'(CHANNELS - 1);
  assign in_ch       = AW'(req_i.channel_index);
  assign cap_ok      = (req_i.req_type == mer_pkg::REQ_CAPTURE) &&
                       (32'(req_i.channel_index) < 32'(CHANNELS));

  // The capture reads its entry at acceptance and writes back one half next cycle.
  assign st_ctrl.rd_en   = issue || (in_acc && cap_ok);
  assign st_ctrl.edge_we = state_q == ST_CAP;
  assign st_ctrl.prev_we = adv && calc_vld;
  assign rd_addr         = issue ? cnt_q : in_ch;
  assign wr_start        = cap_rise_q ? cap_val_q : rd_start;
  assign wr_end          = cap_rise_q ? rd_end : cap_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      exp_q    <= '1;
      period_q <= mer_pkg::TIMER_PERIOD_RST;
      limit_q  <= mer_pkg::JUMP_LIMIT_RST;
      a_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mer_pkg::CFG_TIMER_PERIOD) begin
          period_q <= cfg_data_i;
        end else if (cfg_idx_i == mer_pkg::CFG_JUMP_LIMIT) begin
          limit_q <= cfg_data_i;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (cap_ok) begin
              exp_q[in_ch] <= ~exp_q[in_ch];
              state_q      <= ST_CAP;
            end else if (req_i.req_type == mer_pkg::REQ_TRIGGER) begin
              exp_q <= '1;
            end else if (req_i.req_type == mer_pkg::REQ_EVALUATE) begin
              cnt_q   <= '0;
              state_q <= ST_EVAL;
            end
          end
        end
        ST_CAP: begin
          state_q <= ST_IDLE;
        end
        ST_EVAL: begin
          if (adv) begin
            cnt_q <= cnt_q + AW'(1);
            if (cnt_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (adv) begin
        a_vld_q   <= issue;
        out_vld_q <= calc_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && cap_ok) begin
      cap_ch_q   <= in_ch;
      cap_val_q  <= COUNT_WIDTH'(req_i.capture_value);
      cap_rise_q <= exp_q[in_ch];
    end
    if (adv) begin
      a_ch_q   <= cnt_q;
      a_last_q <= cnt_last;
      if (calc_vld) begin
        out_ch_q   <= mer_pkg::CH_FIELD_W'(d_ch);
        out_raw_q  <= calc_raw;
        out_acc_q  <= reject ? d_prev : calc_raw;
        out_rej_q  <= reject;
        out_last_q <= d_last;
      end
    end
  end

  mer_store #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (st_ctrl),
    .rd_addr_i       (rd_addr),
    .edge_wr_addr_i  (cap_ch_q),
    .edge_wr_start_i (wr_start),
    .edge_wr_end_i   (wr_end),
    .prev_wr_addr_i  (d_ch),
    .prev_wr_data_i  (calc_raw),
    .rd_start_o      (rd_start),
    .rd_end_o        (rd_end),
    .rd_prev_o       (rd_prev)
  );

  mer_calc #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TAG_W       (TAG_W)
  ) u_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (a_vld_q),
    .start_i  (rd_start),
    .end_i    (rd_end),
    .period_i (period_q),
    .tag_i    ({rd_prev, a_ch_q, a_last_q}),
    .vld_o    (calc_vld),
    .raw_o    (calc_raw),
    .tag_o    (calc_tag),
    .busy_o   (calc_busy)
  );

  assign d_prev = calc_tag[TAG_W-1 -: mer_pkg::RAW_W];
  assign d_ch   = calc_tag[AW:1];
  assign d_last = calc_tag[0];
  assign diff   = (calc_raw > d_prev) ? calc_raw - d_prev : d_prev - calc_raw;
  assign reject = mer_pkg::REG_W'(diff) > limit_q;

  assign res_o.valid             = out_vld_q;
  assign res_o.out_channel       = out_ch_q;
  assign res_o.raw_distance      = out_raw_q;
  assign res_o.accepted_distance = out_acc_q;
  assign res_o.jump_rejected     = out_rej_q;
  assign res_o.last_result       = out_last_q;

endmodule

`default_nettype wire
